// ===== src/ubhd_pkg.sv =====
// ----------------------------------------------------------------------------
// ubhd_pkg
// Shared constants, request codes, ring pointer helpers and the
// controller-to-datapath command bundle of the buffered UART channel.
// ----------------------------------------------------------------------------
package ubhd_pkg;

   // Ring geometry: each ring keeps at most QUEUE_DEPTH-1 bytes.
   localparam int QUEUE_DEPTH = 512;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);

   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [PTR_W-1:0] FULL_FILL = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [PTR_W:0]   DEPTH_EXT = (PTR_W + 1)'(QUEUE_DEPTH);

   // Field widths.
   localparam int ACTION_W = 3;
   localparam int BYTE_W   = 8;
   localparam int COUNT_W  = 9;
   localparam int TICKS_W  = 16;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 1;
   localparam int RSP_W    = 40;

   // Request codes.
   localparam logic [ACTION_W-1:0] ACT_RX_BYTE    = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_HOST_WRITE = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_HOST_READ  = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_TX_READY   = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_TX_DONE    = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_TICK       = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_RX_CLEAR   = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_NOP        = 3'd7;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_IDLE_TICKS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RS485_DIR  = 1'd1;

   localparam logic [TICKS_W-1:0] IDLE_TICKS_RESET = 16'd10;

   typedef struct packed {
      logic exec;   // request accepted: update state, read rings
      logic load;   // capture the result into the output register
   } ubhd_cmd_type;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] nxt;
      nxt = (ptr == LAST_PTR) ? '0 : ptr + 1'b1;
      return nxt;
   endfunction

   function automatic logic [PTR_W-1:0] ring_fill(input logic [PTR_W-1:0] head,
                                                  input logic [PTR_W-1:0] tail);
      logic [PTR_W:0] diff;
      diff = {1'b0, head} - {1'b0, tail};
      if (head < tail) begin
         diff = diff + DEPTH_EXT;
      end
      return diff[PTR_W-1:0];
   endfunction

endpackage

// ===== src/uart_buffered_half_duplex_channel.sv =====
// ----------------------------------------------------------------------------
// uart_buffered_half_duplex_channel
// Buffered half-duplex UART channel: receive ring, transmit ring, idle
// countdown for frame end and RS485 driver direction control.
// ----------------------------------------------------------------------------
// Timing: an accepted request updates state and reads the rings into
//   registers, then its response loads into the output register once free.
// A new request is taken only after the previous result has loaded, since
//   the registered ring read data is consumed in that load step.
// Reset: synchronous, active high; clears pointers, countdown and direction
//   state, loads idle_ticks = 10 and rs485_direction = 1. Ring contents are
//   not cleared; no clearing pass is needed.
// ----------------------------------------------------------------------------
module uart_buffered_half_duplex_channel
   import ubhd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [BYTE_W-1:0]    req_tdata,   // [7:0] data_byte
   input  logic [ACTION_W-1:0]  req_tuser,   // [2:0] action
   input  logic                 req_tlast,   // write_last
   // response channel
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RSP_W-1:0]     rsp_tdata,   // [0] ok, [8:1] read_byte, [9] tx_valid,
                                             // [17:10] tx_byte, [18] frame_end,
                                             // [27:19] rx_count, [36:28] tx_count,
                                             // [37] drive_enable, [38] receive_on,
                                             // [39] zero
   // configuration
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_addr,
   input  logic [CSR_W-1:0]     csr_wdata
);

   ubhd_cmd_type cmd;

   // Sequencer: take one request, execute, then park the response in the
   // output register; a new request may arrive while that response waits.
   ubhd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // Rings, countdown, direction flags and the response register.
   // The request payload is sampled in the accept cycle, when cmd.exec is high.
   ubhd_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .action     (req_tuser),
      .data_byte  (req_tdata),
      .write_last (req_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rsp_word   (rsp_tdata)
   );

endmodule

// ===== src/ubhd_ctrl.sv =====
// ----------------------------------------------------------------------------
// ubhd_ctrl
// Request sequencer: accepts one request, lets the datapath execute it,
// then hands the result to the output register once that is free.
// ----------------------------------------------------------------------------
module ubhd_ctrl
   import ubhd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output ubhd_cmd_type cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic slot_free;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd.exec     = 1'b0;
      cmd.load     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.exec = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // hold the finished result until the output register drains
            if (slot_free) begin
               cmd.load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   property p_load_only_from_exec;
      @(posedge clock) disable iff (reset) cmd.load |-> $past(cmd.exec) || (state_ff == ST_EXEC);
   endproperty
   a_load_only_from_exec: assert property (p_load_only_from_exec)
      else $error("result loaded without an executed request");

   property p_no_overwrite;
      @(posedge clock) disable iff (reset) (rsp_valid_ff && !rsp_tready) |-> !cmd.load;
   endproperty
   a_no_overwrite: assert property (p_no_overwrite)
      else $error("pending result overwritten");

   property p_exec_then_wait;
      @(posedge clock) disable iff (reset) cmd.exec |=> !req_tready;
   endproperty
   a_exec_then_wait: assert property (p_exec_then_wait)
      else $error("new request taken before the previous one finished");

endmodule

// ===== src/ubhd_datapath.sv =====
// ----------------------------------------------------------------------------
// ubhd_datapath
// Receive and transmit rings, idle countdown, direction control and the
// result register of the buffered UART channel.
// ----------------------------------------------------------------------------
module ubhd_datapath
   import ubhd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  ubhd_cmd_type         cmd,
   input  logic [ACTION_W-1:0]  action,
   input  logic [BYTE_W-1:0]    data_byte,
   input  logic                 write_last,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_addr,
   input  logic [CSR_W-1:0]     csr_wdata,
   output logic [RSP_W-1:0]     rsp_word
);

   logic [BYTE_W-1:0] rx_mem [QUEUE_DEPTH];
   logic [BYTE_W-1:0] tx_mem [QUEUE_DEPTH];

   logic [TICKS_W-1:0] idle_ticks_ff;
   logic               rs485_ff;

   logic [PTR_W-1:0] rx_head_ff, rx_head_in, rx_tail_ff, rx_tail_in;
   logic [PTR_W-1:0] tx_head_ff, tx_head_in, tx_tail_ff, tx_tail_in;
   logic             frame_pending_ff, frame_pending_in;
   logic [TICKS_W-1:0] idle_count_ff, idle_count_in;
   logic             tx_running_ff, tx_running_in;
   logic             await_ff, await_in;
   logic             driver_ff, driver_in;
   logic             rx_allowed_ff, rx_allowed_in;

   logic ok_ff, ok_in;
   logic rx_hit_ff, rx_hit_in;
   logic tx_hit_ff, tx_hit_in;
   logic fend_ff, fend_in;
   logic [BYTE_W-1:0] rx_rd_ff, tx_rd_ff;
   logic [RSP_W-1:0]  rsp_ff, rsp_in;

   logic rx_we, tx_we;
   logic [PTR_W-1:0] rx_fill, tx_fill;
   logic [BYTE_W-1:0] read_byte, tx_byte;

   assign rx_fill = ring_fill(rx_head_ff, rx_tail_ff);
   assign tx_fill = ring_fill(tx_head_ff, tx_tail_ff);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         idle_ticks_ff <= IDLE_TICKS_RESET;
         rs485_ff      <= 1'b1;
      end else if (csr_we) begin
         if (csr_addr == REG_IDLE_TICKS) begin
            idle_ticks_ff <= csr_wdata[TICKS_W-1:0];
         end
         if (csr_addr == REG_RS485_DIR) begin
            rs485_ff <= csr_wdata[0];
         end
      end
   end

   always_comb begin
      rx_head_in       = rx_head_ff;
      rx_tail_in       = rx_tail_ff;
      tx_head_in       = tx_head_ff;
      tx_tail_in       = tx_tail_ff;
      frame_pending_in = frame_pending_ff;
      idle_count_in    = idle_count_ff;
      tx_running_in    = tx_running_ff;
      await_in         = await_ff;
      driver_in        = driver_ff;
      rx_allowed_in    = rx_allowed_ff;
      ok_in            = 1'b0;
      rx_hit_in        = 1'b0;
      tx_hit_in        = 1'b0;
      fend_in          = 1'b0;
      rx_we            = 1'b0;
      tx_we            = 1'b0;
      if (cmd.exec) begin
         unique case (action)
            ACT_RX_BYTE: begin
               if (rx_allowed_ff) begin
                  frame_pending_in = 1'b1;
                  idle_count_in    = idle_ticks_ff;
                  if (rx_fill != FULL_FILL) begin
                     rx_we      = 1'b1;
                     rx_head_in = ptr_inc(rx_head_ff);
                     ok_in      = 1'b1;
                  end
               end
            end
            ACT_HOST_WRITE: begin
               if (tx_fill != FULL_FILL) begin
                  tx_we      = 1'b1;
                  tx_head_in = ptr_inc(tx_head_ff);
                  ok_in      = 1'b1;
               end
               if (write_last) begin
                  driver_in     = driver_ff | rs485_ff;
                  rx_allowed_in = 1'b0;
                  tx_running_in = 1'b1;
                  await_in      = 1'b0;
               end
            end
            ACT_HOST_READ: begin
               if (rx_fill != '0) begin
                  ok_in      = 1'b1;
                  rx_hit_in  = 1'b1;
                  rx_tail_in = ptr_inc(rx_tail_ff);
               end
            end
            ACT_TX_READY: begin
               if (tx_running_ff) begin
                  ok_in = 1'b1;
                  if (tx_fill != '0) begin
                     tx_hit_in  = 1'b1;
                     tx_tail_in = ptr_inc(tx_tail_ff);
                  end else begin
                     tx_running_in = 1'b0;
                     await_in      = 1'b1;
                  end
               end
            end
            ACT_TX_DONE: begin
               if (await_ff && (tx_fill == '0)) begin
                  ok_in         = 1'b1;
                  driver_in     = 1'b0;
                  await_in      = 1'b0;
                  rx_allowed_in = 1'b1;
               end
            end
            ACT_TICK: begin
               ok_in = 1'b1;
               if (frame_pending_ff) begin
                  if (idle_count_ff == '0) begin
                     frame_pending_in = 1'b0;
                     fend_in          = 1'b1;
                  end else begin
                     idle_count_in = idle_count_ff - 1'b1;
                  end
               end
            end
            ACT_RX_CLEAR: begin
               rx_head_in = '0;
               rx_tail_in = '0;
               ok_in      = 1'b1;
            end
            ACT_NOP: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_head_ff       <= '0;
         rx_tail_ff       <= '0;
         tx_head_ff       <= '0;
         tx_tail_ff       <= '0;
         frame_pending_ff <= 1'b0;
         idle_count_ff    <= '0;
         tx_running_ff    <= 1'b0;
         await_ff         <= 1'b0;
         driver_ff        <= 1'b0;
         rx_allowed_ff    <= 1'b1;
      end else begin
         rx_head_ff       <= rx_head_in;
         rx_tail_ff       <= rx_tail_in;
         tx_head_ff       <= tx_head_in;
         tx_tail_ff       <= tx_tail_in;
         frame_pending_ff <= frame_pending_in;
         idle_count_ff    <= idle_count_in;
         tx_running_ff    <= tx_running_in;
         await_ff         <= await_in;
         driver_ff        <= driver_in;
         rx_allowed_ff    <= rx_allowed_in;
      end
   end

   // Ring memories: read the oldest entry of each ring as the request executes.
   always_ff @(posedge clock) begin
      if (rx_we) begin
         rx_mem[rx_head_ff] <= data_byte;
      end
      if (tx_we) begin
         tx_mem[tx_head_ff] <= data_byte;
      end
      if (cmd.exec) begin
         rx_rd_ff <= rx_mem[rx_tail_ff];
         tx_rd_ff <= tx_mem[tx_tail_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         ok_ff     <= ok_in;
         rx_hit_ff <= rx_hit_in;
         tx_hit_ff <= tx_hit_in;
         fend_ff   <= fend_in;
      end
   end

   assign read_byte = rx_hit_ff ? rx_rd_ff : '0;
   assign tx_byte   = tx_hit_ff ? tx_rd_ff : '0;

   assign rsp_in = {1'b0, rx_allowed_ff, driver_ff,
                    COUNT_W'(tx_fill), COUNT_W'(rx_fill),
                    fend_ff, tx_byte, tx_hit_ff, read_byte, ok_ff};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_word = rsp_ff;

   property p_tx_phase_exclusive;
      @(posedge clock) disable iff (reset) !(tx_running_ff && await_ff);
   endproperty
   a_tx_phase_exclusive: assert property (p_tx_phase_exclusive)
      else $error("transmit running and awaiting completion at once");

   property p_driver_blocks_rx;
      @(posedge clock) disable iff (reset) driver_ff |-> !rx_allowed_ff;
   endproperty
   a_driver_blocks_rx: assert property (p_driver_blocks_rx)
      else $error("driver enabled while reception is on");

   property p_tx_phase_blocks_rx;
      @(posedge clock) disable iff (reset) (tx_running_ff || await_ff) |-> !rx_allowed_ff;
   endproperty
   a_tx_phase_blocks_rx: assert property (p_tx_phase_blocks_rx)
      else $error("reception on during a transmit batch");

endmodule

// ===== tb/tb_uart_buffered_half_duplex_channel.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_uart_buffered_half_duplex_channel
// Self-checking bench for the buffered half-duplex UART channel. A directed
// table walks the corner cases from reset. Random traffic follows under
// several register settings: receive frames, transmit batches, ring floods and
// noise. Every response is checked field by field against its row's answer or
// a behavioral predictor of both rings, idle countdown and line direction.
// ----------------------------------------------------------------------------
module tb_uart_buffered_half_duplex_channel;
   import ubhd_pkg::*;

   localparam int          DIR_ROWS    = 24;
   localparam int          HOLD_CYCLES = 400;
   localparam int unsigned CYCLE_LIMIT = 500_000;

   // Response layout, lowest bit last.
   typedef struct packed {
      logic               pad;
      logic               receive_on;
      logic               drive_enable;
      logic [COUNT_W-1:0] tx_count;
      logic [COUNT_W-1:0] rx_count;
      logic               frame_end;
      logic [BYTE_W-1:0]  tx_byte;
      logic               tx_valid;
      logic [BYTE_W-1:0]  read_byte;
      logic               ok;
   } chan_rsp_t;

   // One row of the directed table; typed = 1 means rsp holds the known answer.
   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [BYTE_W-1:0]   data;
      logic                last;
      logic                typed;
      chan_rsp_t           rsp;
   } stim_row_t;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [BYTE_W-1:0]    req_tdata = '0;
   logic [ACTION_W-1:0]  req_tuser = ACT_NOP;
   logic                 req_tlast = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_addr = REG_IDLE_TICKS;
   logic [CSR_W-1:0]     csr_wdata = '0;

   // Shared control between the stimulus and the receiver process.
   bit quiet = 1'b0;          // no idling on either side
   bit hold_off_req = 1'b0;   // ask the receiver for one long hold-off
   bit hold_off_done = 1'b0;

   int unsigned sent_count = 0;
   int unsigned checked_count = 0;
   int unsigned fail_count = 0;
   int unsigned frame_count = 0;
   int unsigned refused_count = 0;
   int unsigned cycle_count = 0;

   chan_rsp_t exp_q [$];      // predicted responses, oldest first
   stim_row_t dir_tab [DIR_ROWS];

   // Predictor state: both rings, countdown, direction control, registers.
   logic [BYTE_W-1:0]  rx_ring [QUEUE_DEPTH];
   logic [BYTE_W-1:0]  tx_ring [QUEUE_DEPTH];
   int                 rx_wr, rx_rd, tx_wr, tx_rd;
   bit                 frame_armed;
   logic [TICKS_W-1:0] idle_left;
   bit                 tx_active;
   bit                 tx_drained;
   bit                 line_driven;
   bit                 rx_enabled;
   logic [TICKS_W-1:0] cfg_idle_ticks;
   bit                 cfg_rs485;

   uart_buffered_half_duplex_channel uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------
   function automatic int fill_level(input int wr, input int rd);
      return (wr + QUEUE_DEPTH - rd) % QUEUE_DEPTH;
   endfunction

   function automatic chan_rsp_t resp_of(input int ok, input logic [7:0] rb,
                                         input int tv, input logic [7:0] tb,
                                         input int fe, input int rxc, input int txc,
                                         input int de, input int ro);
      chan_rsp_t r;
      r              = '0;
      r.ok           = 1'(ok);
      r.read_byte    = rb;
      r.tx_valid     = 1'(tv);
      r.tx_byte      = tb;
      r.frame_end    = 1'(fe);
      r.rx_count     = COUNT_W'(rxc);
      r.tx_count     = COUNT_W'(txc);
      r.drive_enable = 1'(de);
      r.receive_on   = 1'(ro);
      return r;
   endfunction

   function automatic void reset_channel_model();
      rx_wr          = 0;
      rx_rd          = 0;
      tx_wr          = 0;
      tx_rd          = 0;
      frame_armed    = 1'b0;
      idle_left      = '0;
      tx_active      = 1'b0;
      tx_drained     = 1'b0;
      line_driven    = 1'b0;
      rx_enabled     = 1'b1;
      cfg_idle_ticks = IDLE_TICKS_RESET;
      cfg_rs485      = 1'b1;
   endfunction

   // Apply one request to the model and return the response it must produce.
   function automatic chan_rsp_t predict_channel(input logic [ACTION_W-1:0] act,
                                                 input logic [BYTE_W-1:0] dat,
                                                 input logic lst);
      chan_rsp_t r;
      r = '0;
      case (act)
         ACT_RX_BYTE: begin
            // bytes arriving while the line is turned around are lost silently
            if (rx_enabled) begin
               frame_armed = 1'b1;
               idle_left   = cfg_idle_ticks;
               if (fill_level(rx_wr, rx_rd) == QUEUE_DEPTH - 1) begin
                  refused_count++;
               end else begin
                  rx_ring[PTR_W'(rx_wr)] = dat;
                  rx_wr                  = (rx_wr + 1) % QUEUE_DEPTH;
                  r.ok                   = 1'b1;
               end
            end
         end
         ACT_HOST_WRITE: begin
            if (fill_level(tx_wr, tx_rd) == QUEUE_DEPTH - 1) begin
               refused_count++;
            end else begin
               tx_ring[PTR_W'(tx_wr)] = dat;
               tx_wr                  = (tx_wr + 1) % QUEUE_DEPTH;
               r.ok                   = 1'b1;
            end
            // end of batch turns the line around even if the byte was refused
            if (lst) begin
               if (cfg_rs485) begin
                  line_driven = 1'b1;
               end
               rx_enabled = 1'b0;
               tx_active  = 1'b1;
               tx_drained = 1'b0;
            end
         end
         ACT_HOST_READ: begin
            if (fill_level(rx_wr, rx_rd) != 0) begin
               r.ok        = 1'b1;
               r.read_byte = rx_ring[PTR_W'(rx_rd)];
               rx_rd       = (rx_rd + 1) % QUEUE_DEPTH;
            end
         end
         ACT_TX_READY: begin
            if (tx_active) begin
               r.ok = 1'b1;
               if (fill_level(tx_wr, tx_rd) != 0) begin
                  r.tx_valid = 1'b1;
                  r.tx_byte  = tx_ring[PTR_W'(tx_rd)];
                  tx_rd      = (tx_rd + 1) % QUEUE_DEPTH;
               end else begin
                  tx_active  = 1'b0;
                  tx_drained = 1'b1;
               end
            end
         end
         ACT_TX_DONE: begin
            if (tx_drained && fill_level(tx_wr, tx_rd) == 0) begin
               r.ok        = 1'b1;
               line_driven = 1'b0;
               tx_drained  = 1'b0;
               rx_enabled  = 1'b1;
            end
         end
         ACT_TICK: begin
            r.ok = 1'b1;
            if (frame_armed) begin
               if (idle_left == 0) begin
                  frame_armed = 1'b0;
                  r.frame_end = 1'b1;
                  frame_count++;
               end else begin
                  idle_left = idle_left - 1'b1;
               end
            end
         end
         ACT_RX_CLEAR: begin
            rx_wr = 0;
            rx_rd = 0;
            r.ok  = 1'b1;
         end
         default: begin
         end
      endcase
      r.rx_count     = COUNT_W'(fill_level(rx_wr, rx_rd));
      r.tx_count     = COUNT_W'(fill_level(tx_wr, tx_rd));
      r.drive_enable = line_driven;
      r.receive_on   = rx_enabled;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------
   // Offer one request, hold it until taken, then queue its expected response.
   // Call only in the time step of a rising edge.
   task automatic send_request(input logic [ACTION_W-1:0] act,
                               input logic [BYTE_W-1:0] dat,
                               input logic lst,
                               input bit use_typed = 1'b0,
                               input chan_rsp_t typed_rsp = '0);
      chan_rsp_t want;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= dat;
      req_tlast  <= lst;
      do @(posedge clock); while (!req_tready);
      want = predict_channel(act, dat, lst);
      if (use_typed) begin
         want = typed_rsp;
      end
      exp_q.push_back(want);
      sent_count++;
   endtask

   // Finish any transmission in progress so that reception is back on.
   task automatic release_line();
      while (!rx_enabled) begin
         if (tx_drained && fill_level(tx_wr, tx_rd) == 0) begin
            send_request(ACT_TX_DONE, 8'($urandom_range(0, 255)), 1'b0);
         end else if (tx_active) begin
            send_request(ACT_TX_READY, 8'($urandom_range(0, 255)), 1'b0);
         end else begin
            // drained with bytes left behind: start a new batch to flush them
            send_request(ACT_HOST_WRITE, 8'($urandom_range(0, 255)), 1'b1);
         end
      end
   endtask

   // Drop valid, wait for every response, let the pipeline settle, then write
   // the idle tick register first and the direction register after it.
   task automatic reconfigure(input logic [TICKS_W-1:0] idle, input logic dir);
      req_tvalid <= 1'b0;
      while (exp_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= REG_IDLE_TICKS;
      csr_wdata <= idle;
      @(posedge clock);
      csr_addr  <= REG_RS485_DIR;
      csr_wdata <= CSR_W'(dir);
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_idle_ticks = idle;
      cfg_rs485      = dir;
   endtask

   // Mostly well-formed frames and batches with random content, some noise.
   task automatic run_mixed_traffic(input int unsigned n_items);
      int unsigned stop_at;
      int unsigned pick;
      int          n;
      int          k;
      stop_at = sent_count + n_items;
      while (sent_count < stop_at) begin
         pick = $urandom_range(0, 9);
         if (pick < 4) begin
            // receive a frame, tick (past the countdown if it is short), read it back
            release_line();
            n = $urandom_range(1, 12);
            for (k = 0; k < n; k++) begin
               send_request(ACT_RX_BYTE, 8'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)));
            end
            n = (cfg_idle_ticks < 16) ? int'(cfg_idle_ticks) + 1 + $urandom_range(0, 2)
                                      : $urandom_range(1, 6);
            for (k = 0; k < n; k++) begin
               send_request(ACT_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
            n = fill_level(rx_wr, rx_rd) + $urandom_range(0, 1);
            for (k = 0; k < n; k++) begin
               send_request(ACT_HOST_READ, 8'($urandom_range(0, 255)), 1'b0);
            end
         end else if (pick < 7) begin
            // host batch, pump the transmitter dry, then release the line
            n = $urandom_range(1, 10);
            for (k = 0; k < n; k++) begin
               send_request(ACT_HOST_WRITE, 8'($urandom_range(0, 255)), k == n - 1);
            end
            while (tx_active) begin
               send_request(ACT_TX_READY, 8'($urandom_range(0, 255)), 1'b0);
            end
            send_request(ACT_TX_DONE, 8'($urandom_range(0, 255)), 1'b0);
         end else begin
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++) begin
               send_request(ACTION_W'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                            $urandom_range(0, 3) == 0);
            end
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------------
   // Stall in random bursts; grant the one long hold-off when asked.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_req && !hold_off_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_done = 1'b1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 16) - 1) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic check_field(input string name, input logic [8:0] want,
                              input logic [8:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      chan_rsp_t got;
      chan_rsp_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = chan_rsp_t'(rsp_tdata);
         if (exp_q.size() == 0) begin
            $display("%0t: response with none expected, expected nothing, actual %h",
                     $time, rsp_tdata);
            fail_count++;
         end else begin
            want = exp_q.pop_front();
            checked_count++;
            check_field("ok",           9'(want.ok),           9'(got.ok));
            check_field("read_byte",    9'(want.read_byte),    9'(got.read_byte));
            check_field("tx_valid",     9'(want.tx_valid),     9'(got.tx_valid));
            check_field("tx_byte",      9'(want.tx_byte),      9'(got.tx_byte));
            check_field("frame_end",    9'(want.frame_end),    9'(got.frame_end));
            check_field("rx_count",     want.rx_count,         got.rx_count);
            check_field("tx_count",     want.tx_count,         got.tx_count);
            check_field("drive_enable", 9'(want.drive_enable), 9'(got.drive_enable));
            check_field("receive_on",   9'(want.receive_on),   9'(got.receive_on));
            check_field("pad",          9'(want.pad),          9'(got.pad));
         end
      end
   end

   // Watchdog: end the run if it hangs.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Test completed with failures");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      int k;
      // Directed walk from reset (idle_ticks 10, RS485 direction on).
      //                    ok  rb     tv  tb     fe rx tx de  ro
      dir_tab = '{
         '{ACT_HOST_READ,  8'h00, 1'b0, 1'b1, resp_of(0, 8'h00, 0, 8'h00, 0, 0, 0, 0, 1)},
         '{ACT_TX_READY,   8'h00, 1'b0, 1'b1, resp_of(0, 8'h00, 0, 8'h00, 0, 0, 0, 0, 1)},
         '{ACT_TX_DONE,    8'h00, 1'b0, 1'b1, resp_of(0, 8'h00, 0, 8'h00, 0, 0, 0, 0, 1)},
         '{ACT_TICK,       8'h00, 1'b0, 1'b1, resp_of(1, 8'h00, 0, 8'h00, 0, 0, 0, 0, 1)},
         '{ACT_NOP,        8'hFF, 1'b1, 1'b1, resp_of(0, 8'h00, 0, 8'h00, 0, 0, 0, 0, 1)},
         '{ACT_RX_BYTE,    8'h00, 1'b0, 1'b1, resp_of(1, 8'h00, 0, 8'h00, 0, 1, 0, 0, 1)},
         '{ACT_RX_BYTE,    8'hFF, 1'b0, 1'b1, resp_of(1, 8'h00, 0, 8'h00, 0, 2, 0, 0, 1)},
         '{ACT_TICK,       8'h00, 1'b0, 1'b0, '0},
         '{ACT_HOST_READ,  8'h00, 1'b0, 1'b1, resp_of(1, 8'h00, 0, 8'h00, 0, 1, 0, 0, 1)},
         '{ACT_HOST_READ,  8'h00, 1'b0, 1'b1, resp_of(1, 8'hFF, 0, 8'h00, 0, 0, 0, 0, 1)},
         '{ACT_RX_BYTE,    8'hA5, 1'b1, 1'b1, resp_of(1, 8'h00, 0, 8'h00, 0, 1, 0, 0, 1)},
         '{ACT_RX_CLEAR,   8'h00, 1'b0, 1'b1, resp_of(1, 8'h00, 0, 8'h00, 0, 0, 0, 0, 1)},
         '{ACT_HOST_WRITE, 8'h00, 1'b0, 1'b1, resp_of(1, 8'h00, 0, 8'h00, 0, 0, 1, 0, 1)},
         '{ACT_HOST_WRITE, 8'hFF, 1'b1, 1'b1, resp_of(1, 8'h00, 0, 8'h00, 0, 0, 2, 1, 0)},
         '{ACT_RX_BYTE,    8'h55, 1'b0, 1'b1, resp_of(0, 8'h00, 0, 8'h00, 0, 0, 2, 1, 0)},
         '{ACT_TX_DONE,    8'h00, 1'b0, 1'b1, resp_of(0, 8'h00, 0, 8'h00, 0, 0, 2, 1, 0)},
         '{ACT_TX_READY,   8'h00, 1'b0, 1'b1, resp_of(1, 8'h00, 1, 8'h00, 0, 0, 1, 1, 0)},
         '{ACT_TX_READY,   8'h00, 1'b0, 1'b1, resp_of(1, 8'h00, 1, 8'hFF, 0, 0, 0, 1, 0)},
         '{ACT_TX_DONE,    8'h00, 1'b0, 1'b1, resp_of(0, 8'h00, 0, 8'h00, 0, 0, 0, 1, 0)},
         '{ACT_TX_READY,   8'h00, 1'b0, 1'b1, resp_of(1, 8'h00, 0, 8'h00, 0, 0, 0, 1, 0)},
         '{ACT_TX_READY,   8'h00, 1'b0, 1'b1, resp_of(0, 8'h00, 0, 8'h00, 0, 0, 0, 1, 0)},
         '{ACT_HOST_READ,  8'h00, 1'b0, 1'b0, '0},
         '{ACT_TX_DONE,    8'h00, 1'b0, 1'b1, resp_of(1, 8'h00, 0, 8'h00, 0, 0, 0, 0, 1)},
         '{ACT_TICK,       8'hFF, 1'b1, 1'b0, '0}
      };
      reset_channel_model();

      // Hold reset, then release it before the first request.
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (k = 0; k < DIR_ROWS; k++) begin
         send_request(dir_tab[k].action, dir_tab[k].data, dir_tab[k].last,
                      dir_tab[k].typed, dir_tab[k].rsp);
      end

      // Shortest countdown, no driver; stall the receiver long enough that
      // the block backs up and stops taking requests.
      reconfigure(16'd0, 1'b0);
      hold_off_req = 1'b1;
      run_mixed_traffic(20);

      // Longest countdown, driver on; flood the receive ring past full, read
      // a few bytes back and empty the rest with a clear.
      reconfigure(16'hFFFF, 1'b1);
      release_line();
      send_request(ACT_RX_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      for (k = 0; k <= QUEUE_DEPTH; k++) begin
         send_request(ACT_RX_BYTE, 8'($urandom_range(0, 255)), 1'b0);
      end
      for (k = 0; k < 8; k++) begin
         send_request(ACT_HOST_READ, 8'($urandom_range(0, 255)), 1'b0);
      end
      send_request(ACT_RX_CLEAR, 8'($urandom_range(0, 255)), 1'b0);
      run_mixed_traffic(20);

      reconfigure(16'd3, 1'b0);
      run_mixed_traffic(20);

      // Last stretch runs back to back with no idling on either side.
      reconfigure(TICKS_W'($urandom_range(1, 6)), 1'b1);
      quiet = 1'b1;
      run_mixed_traffic(20);

      // Drain the tail and let the pipeline settle before judging.
      req_tvalid <= 1'b0;
      while (exp_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d requests under five register settings, checked %0d responses.",
               sent_count, checked_count);
      $display("Saw %0d frame ends and %0d bytes refused by a full ring.",
               frame_count, refused_count);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
